### hw/rtl/sorted_list_insert_search_assert.svh
// assertion macros for the sorted list block
`ifndef SORTED_LIST_INSERT_SEARCH_ASSERT_SVH
`define SORTED_LIST_INSERT_SEARCH_ASSERT_SVH

// same-cycle implication
`define SLI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sorted list check failed");

// next-cycle implication
`define SLI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sorted list check failed");

`endif

### hw/rtl/sli_pkg.sv
`default_nettype none
package sli_pkg;

  localparam int DEPTH     = 16;
  localparam int VALUE_W   = 16;
  localparam int POS_W     = $clog2(DEPTH + 1);
  localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((POS_W + 7) / 8) * 8;
  localparam int S_TUSER_W = 1;
  localparam int M_TUSER_W = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic ins;
    logic occ;
  } cell_ctl_t;

  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage
`default_nettype wire

### hw/rtl/sli_cell.sv
`default_nettype none
module sli_cell (
  input  wire logic                 clk,
  input  wire sli_pkg::cell_ctl_t   ctl,
  input  wire logic                 prev_le,
  input  wire sli_pkg::value_t      prev_entry,
  input  wire sli_pkg::value_t      v,
  output sli_pkg::cell_flags_t      flags,
  output sli_pkg::value_t           entry
);
  import sli_pkg::*;

  value_t stored;

  assign entry    = stored;
  assign flags.le = ctl.occ && (stored <= v);
  assign flags.lt = ctl.occ && (stored < v);
  assign flags.eq = ctl.occ && (stored == v);

  // larger entries move up one place, the new value lands at the boundary
  always_ff @(posedge clk) begin
    if (ctl.ins && !flags.le) begin
      stored <= prev_le ? v : prev_entry;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_list_insert_search.sv
// channel  dir  signals                          beat contents
// s        in   s_tvalid s_tready s_tdata s_tuser value, func
// m        out  m_tvalid m_tready m_tdata m_tuser position, found / full_res
//
// for every item all cells compare against the value at once,
// the boundary cell is encoded and the result goes to the output register
// one item per cycle is accepted while the output register is free or drained
// rst clears the count and the output valid; stored entries need no reset
// a stalled result holds s_tready low until it is taken
`default_nettype none
`include "sorted_list_insert_search_assert.svh"
module sorted_list_insert_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [sli_pkg::S_TDATA_W-1:0] s_tdata,  // value
  input  wire logic [sli_pkg::S_TUSER_W-1:0] s_tuser,  // func
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [sli_pkg::M_TDATA_W-1:0]      m_tdata,  // position, zero pad
  output logic [sli_pkg::M_TUSER_W-1:0]      m_tuser   // found, full_res
);
  import sli_pkg::*;

  logic        s_go;
  logic        func;
  value_t      v;
  logic        full;
  logic        ins_go;
  pos_t        count;
  pos_t        count_next;
  pos_t        le_pos;
  pos_t        lt_pos;
  logic        le_any;
  logic        hit;
  logic        res_found;
  logic        res_full;
  pos_t        res_pos;
  logic        r_found;
  logic        r_full;
  pos_t        r_pos;

  cell_ctl_t   ctl   [DEPTH];
  cell_flags_t flags [DEPTH];
  value_t      entry [DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign s_go     = s_tvalid && s_tready;
  assign func     = s_tuser[0];
  assign v        = s_tdata[VALUE_W-1:0];
  assign full     = (count == pos_t'(DEPTH));
  assign ins_go   = s_go && (func == FUNC_INSERT) && !full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].ins = ins_go;
    assign ctl[i].occ = (count > pos_t'(i));
    if (i == 0) begin : g_head
      sli_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .prev_le    (1'b0),
        .prev_entry (v),
        .v          (v),
        .flags      (flags[i]),
        .entry      (entry[i])
      );
    end else begin : g_body
      sli_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .prev_le    (flags[i-1].le),
        .prev_entry (entry[i-1]),
        .v          (v),
        .flags      (flags[i]),
        .entry      (entry[i])
      );
    end
  end

  // boundary encode: cells below the boundary compare true, the rest false
  always_comb begin
    le_pos = '0;
    lt_pos = '0;
    le_any = 1'b0;
    hit    = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!flags[i].le && (i == 0 || flags[(i == 0) ? 0 : i-1].le)) begin
        le_pos = le_pos | pos_t'(i);
        le_any = 1'b1;
      end
      if (!flags[i].lt && (i == 0 || flags[(i == 0) ? 0 : i-1].lt)) begin
        lt_pos = lt_pos | pos_t'(i);
        hit    = hit | flags[i].eq;
      end
    end
  end

  always_comb begin
    res_found = 1'b0;
    res_full  = 1'b0;
    res_pos   = count;
    if (func == FUNC_INSERT) begin
      if (full) begin
        res_full = 1'b1;
      end else begin
        res_found = 1'b1;
        res_pos   = le_any ? le_pos : count;
      end
    end else if (hit) begin
      res_found = 1'b1;
      res_pos   = lt_pos;
    end
  end

  assign count_next = ins_go ? count + pos_t'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      r_found <= res_found;
      r_full  <= res_full;
      r_pos   <= res_pos;
    end
  end

  assign m_tdata = {{(M_TDATA_W-POS_W){1'b0}}, r_pos};
  assign m_tuser = {r_full, r_found};

  `SLI_ASSERT_NOW(a_count_range, 1'b1, count <= pos_t'(DEPTH))
  `SLI_ASSERT_NEXT(a_count_inc, ins_go, count == $past(count) + pos_t'(1))
  `SLI_ASSERT_NEXT(a_empty_find, s_go && func == FUNC_FIND && count == '0, !r_found && r_pos == '0)
  `SLI_ASSERT_NEXT(a_full_refuse, s_go && func == FUNC_INSERT && full, r_full && $stable(count))

endmodule
`default_nettype wire
